### sv/spqo_pkg.sv
`timescale 1ns / 1ps

package spqo_pkg;

  localparam int NUM_CLS = 3;

  // traffic classes
  localparam logic [1:0] CLS_LOW    = 2'd0;
  localparam logic [1:0] CLS_NORMAL = 2'd1;
  localparam logic [1:0] CLS_HIGH   = 2'd2;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 144;

  // result record minus the dequeued word, which arrives from the ring RAM in the cycle after
  typedef struct packed {
    logic        accepted;
    logic        pop_hit;
    logic [1:0]  out_class;
    logic        dropped_oldest;
    logic [5:0]  total_count;
    logic [31:0] overflow_total;
    logic [31:0] overflow_of_class;
  } res_t;

endpackage

### sv/spqo_ram.sv
`timescale 1ns / 1ps

module spqo_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/spqo_ctrl.sv
`timescale 1ns / 1ps

module spqo_ctrl #(
  parameter int RING_DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             fire,
  input  logic [1:0]                       operation,
  input  logic [7:0]                       priority_req,
  output logic                             ram_we,
  output logic [$clog2(3*RING_DEPTH)-1:0]  ram_waddr,
  output logic                             ram_re,
  output logic [$clog2(3*RING_DEPTH)-1:0]  ram_raddr,
  output spqo_pkg::res_t                   res
);

  import spqo_pkg::*;

  localparam int PW  = $clog2(RING_DEPTH);
  localparam int FW  = $clog2(RING_DEPTH + 1);
  localparam int TW  = $clog2(3 * RING_DEPTH + 1);
  localparam int TXW = (TW > 6) ? TW : 6;
  localparam int AW  = $clog2(3 * RING_DEPTH);

  logic [PW-1:0] rptr_r [NUM_CLS];
  logic [PW-1:0] rptr_nxt [NUM_CLS];
  logic [PW-1:0] wptr_r [NUM_CLS];
  logic [PW-1:0] wptr_nxt [NUM_CLS];
  logic [FW-1:0] fill_r [NUM_CLS];
  logic [FW-1:0] fill_nxt [NUM_CLS];
  logic [31:0]   ovf_cls_r [NUM_CLS];
  logic [31:0]   ovf_cls_nxt [NUM_CLS];
  logic [TW-1:0] total_r;
  logic [TW-1:0] total_nxt;
  logic [31:0]   ovf_sum_r;
  logic [31:0]   ovf_sum_nxt;

  logic       do_push;
  logic       do_pop;
  logic       do_clear;
  logic [1:0] cls;
  logic       full;
  logic       pop_any;
  logic [1:0] pop_cls;
  logic       push_store;
  logic [TXW-1:0] total_ext;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(RING_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_comb begin
    do_push  = 1'b0;
    do_pop   = 1'b0;
    do_clear = 1'b0;
    case (operation)
      OP_PUSH:  do_push  = fire;
      OP_POP:   do_pop   = fire;
      OP_CLEAR: do_clear = fire;
      default:  ;
    endcase
  end

  assign cls  = (priority_req > 8'(CLS_HIGH)) ? CLS_NORMAL : priority_req[1:0];
  assign full = (fill_r[cls] == FW'(RING_DEPTH));

  always_comb begin
    pop_any = 1'b1;
    pop_cls = CLS_LOW;
    if (fill_r[CLS_HIGH] != '0) begin
      pop_cls = CLS_HIGH;
    end else if (fill_r[CLS_NORMAL] != '0) begin
      pop_cls = CLS_NORMAL;
    end else if (fill_r[CLS_LOW] != '0) begin
      pop_cls = CLS_LOW;
    end else begin
      pop_any = 1'b0;
    end
  end

  // normal class overwrites: oldest entry goes, new one is stored
  assign push_store = do_push && (!full || cls == CLS_NORMAL);

  assign ram_we    = push_store;
  assign ram_waddr = AW'(AW'(cls) * AW'(RING_DEPTH)) + AW'(wptr_r[cls]);
  assign ram_re    = do_pop && pop_any;
  assign ram_raddr = AW'(AW'(pop_cls) * AW'(RING_DEPTH)) + AW'(rptr_r[pop_cls]);

  always_comb begin
    for (int k = 0; k < NUM_CLS; k++) begin
      rptr_nxt[k]    = rptr_r[k];
      wptr_nxt[k]    = wptr_r[k];
      fill_nxt[k]    = fill_r[k];
      ovf_cls_nxt[k] = ovf_cls_r[k];
      if (do_clear) begin
        rptr_nxt[k]    = '0;
        wptr_nxt[k]    = '0;
        fill_nxt[k]    = '0;
        ovf_cls_nxt[k] = '0;
      end else if (do_push && cls == 2'(k)) begin
        if (full) begin
          ovf_cls_nxt[k] = ovf_cls_r[k] + 32'd1;
          if (cls == CLS_NORMAL) begin
            rptr_nxt[k] = ptr_inc(rptr_r[k]);
            wptr_nxt[k] = ptr_inc(wptr_r[k]);
          end
        end else begin
          wptr_nxt[k] = ptr_inc(wptr_r[k]);
          fill_nxt[k] = fill_r[k] + FW'(1);
        end
      end else if (do_pop && pop_any && pop_cls == 2'(k)) begin
        rptr_nxt[k] = ptr_inc(rptr_r[k]);
        fill_nxt[k] = fill_r[k] - FW'(1);
      end
    end
  end

  always_comb begin
    total_nxt   = total_r;
    ovf_sum_nxt = ovf_sum_r;
    if (do_clear) begin
      total_nxt   = '0;
      ovf_sum_nxt = '0;
    end else if (do_push) begin
      if (full) begin
        ovf_sum_nxt = ovf_sum_r + 32'd1;
      end else begin
        total_nxt = total_r + TW'(1);
      end
    end else if (do_pop && pop_any) begin
      total_nxt = total_r - TW'(1);
    end
  end

  assign total_ext = TXW'(total_nxt);

  always_comb begin
    res.accepted          = push_store || ram_re;
    res.pop_hit           = ram_re;
    res.out_class         = ram_re ? pop_cls : CLS_LOW;
    res.dropped_oldest    = do_push && full && cls == CLS_NORMAL;
    res.total_count       = total_ext[5:0];
    res.overflow_total    = ovf_sum_nxt;
    res.overflow_of_class = ovf_cls_nxt[cls];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_CLS; k++) begin
        rptr_r[k]    <= '0;
        wptr_r[k]    <= '0;
        fill_r[k]    <= '0;
        ovf_cls_r[k] <= '0;
      end
      total_r   <= '0;
      ovf_sum_r <= '0;
    end else begin
      for (int k = 0; k < NUM_CLS; k++) begin
        rptr_r[k]    <= rptr_nxt[k];
        wptr_r[k]    <= wptr_nxt[k];
        fill_r[k]    <= fill_nxt[k];
        ovf_cls_r[k] <= ovf_cls_nxt[k];
      end
      total_r   <= total_nxt;
      ovf_sum_r <= ovf_sum_nxt;
    end
  end

  logic [TW-1:0] fill_sum;
  assign fill_sum = TW'(fill_r[CLS_LOW]) + TW'(fill_r[CLS_NORMAL]) + TW'(fill_r[CLS_HIGH]);

`ifndef SYNTHESIS
  a_total_matches_rings: assert property (@(posedge clk) disable iff (!rst_n)
    total_r == fill_sum)
    else $error("overall fill differs from sum of ring fills");

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r[CLS_LOW] <= FW'(RING_DEPTH) && fill_r[CLS_NORMAL] <= FW'(RING_DEPTH) &&
    fill_r[CLS_HIGH] <= FW'(RING_DEPTH))
    else $error("ring fill above depth");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    do_clear |=> total_r == '0 && ovf_sum_r == '0)
    else $error("clear left state behind");

  a_no_write_when_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |-> !ram_we && !ram_re)
    else $error("ring RAM accessed without a transfer");
`endif

endmodule

### sv/strict_priority_queue_overflow.sv
// Three-class strict priority queue (low, normal, high), RING_DEPTH words per class, in one
// ring RAM. Input tdata carries an operation: push (to the class in priority_req; values
// above high mean normal), pop (oldest word of the highest non-empty class) or clear (empty
// all rings, zero all counters). A push to a full ring bumps the total and per-class
// overflow counters; a full low or high ring discards the new word, a full normal ring
// discards its oldest word and stores the new one. Every input transfer yields exactly one
// result transfer. One input transfer is taken per clock cycle while the result side keeps
// up. At the edge of an input transfer the result record is captured in stage one and the
// ring RAM read is started; stage one then passes to the output register, which drives
// out_tvalid, once that register is free or being read out. A stalled output register
// holds off the input only once stage one is occupied as well.
// Only the low PAYLOAD_BITS bits of a word are stored; the rest return as zero.
`timescale 1ns / 1ps

module strict_priority_queue_overflow #(
  parameter int RING_DEPTH   = 16,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // operation[1:0], priority_req[9:2], payload[73:10], zero fill above
  input  logic [spqo_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // accepted[0], out_payload[64:1], out_class[66:65], dropped_oldest[67],
  // total_count[73:68], overflow_total[105:74], overflow_of_class[137:106], zero fill above
  output logic [spqo_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  import spqo_pkg::*;

  localparam int AW = $clog2(3 * RING_DEPTH);

  logic                    in_fire;
  logic                    advance;
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic                    ram_re;
  logic [AW-1:0]           ram_raddr;
  logic [PAYLOAD_BITS-1:0] ram_rdata;
  res_t                    res;

  logic s1_v_r;
  logic s1_v_nxt;
  res_t s1_r;
  logic out_v_r;
  logic out_v_nxt;
  res_t out_res_r;
  logic [63:0] out_pay_r;

  assign advance   = !out_v_r || out_tready;
  assign in_tready = !s1_v_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  spqo_ctrl #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (in_fire),
    .operation    (in_tdata[1:0]),
    .priority_req (in_tdata[9:2]),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr),
    .res          (res)
  );

  spqo_ram #(
    .WIDTH (PAYLOAD_BITS),
    .DEPTH (3 * RING_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_tdata[10 +: PAYLOAD_BITS]),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_fire) begin
      s1_v_nxt = 1'b1;
    end else if (advance) begin
      s1_v_nxt = 1'b0;
    end
    out_v_nxt = advance ? s1_v_r : out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // RAM read data is valid the cycle after the pop transfer, i.e. while it sits in stage one
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= res;
    end
    if (advance && s1_v_r) begin
      out_res_r <= s1_r;
      out_pay_r <= s1_r.pop_hit ? 64'(ram_rdata) : '0;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'd0,
                       out_res_r.overflow_of_class,
                       out_res_r.overflow_total,
                       out_res_r.total_count,
                       out_res_r.dropped_oldest,
                       out_res_r.out_class,
                       out_pay_r,
                       out_res_r.accepted};

`ifndef SYNTHESIS
  a_ready_when_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_v_r |-> in_tready)
    else $error("input stalled with result register free");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && advance |=> out_v_r)
    else $error("stage one result lost");

  a_pop_result_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_pay_r != '0 |-> out_res_r.accepted && out_res_r.pop_hit)
    else $error("payload returned without a pop");
`endif

endmodule
